// ===== rtl/bcg_pkg.sv =====
// package: per-button state record, phase codes and register indexes
`default_nettype none
package bcg_pkg;

  // phase codes of the per-button machine
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_DEBOUNCE = 3'd1;
  localparam logic [2:0] PH_PRESSED  = 3'd2;
  localparam logic [2:0] PH_RELEASE  = 3'd3;
  localparam logic [2:0] PH_WAIT2    = 3'd4;
  localparam logic [2:0] PH_LONG     = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [1:0] REG_DBL_GAP    = 2'd2;
  localparam logic [1:0] REG_CLICK_MAX  = 2'd3;

  // configuration reset values
  localparam logic [15:0] DEBOUNCE_RST   = 16'd10;
  localparam logic [31:0] LONG_PRESS_RST = 32'd3000;
  localparam logic [15:0] DBL_GAP_RST    = 16'd181;
  localparam logic [27:0] CLICK_MAX_RST  = 28'h000007C;

  // one button's state as kept in the state memory
  typedef struct packed {
    logic [2:0]  phase;
    logic [31:0] start_time;
    logic [31:0] press_duration;
    logic [1:0]  click_count;
    logic        previous_pressed;
    logic        long_fired;
  } button_rec_t;

endpackage
`default_nettype wire

// ===== rtl/bcg_in_if.sv =====
// interface: poll transaction channel
`default_nettype none
interface bcg_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  button_index;
  logic        pin_level;
  logic [31:0] time_ms;

  modport source (output valid, button_index, pin_level, time_ms, input ready);
  modport sink   (input valid, button_index, pin_level, time_ms, output ready);
endinterface
`default_nettype wire

// ===== rtl/bcg_out_if.sv =====
// interface: gesture result transaction channel
`default_nettype none
interface bcg_out_if;
  logic valid;
  logic ready;
  logic pressed;
  logic click_event;
  logic double_click_event;
  logic long_press_event;

  modport source (output valid, pressed, click_event, double_click_event, long_press_event,
                  input ready);
  modport sink   (input valid, pressed, click_event, double_click_event, long_press_event,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/bcg_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none
module bcg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic                                       re,
  input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr,
  output      logic [WIDTH-1:0]                           rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/button_click_gesture_detector.sv =====
// top level: per-button click, double click and long press detector
//
//  channel   dir  handshake        payload
//  in_ch     in   valid / ready    button_index[3:0], pin_level, time_ms[31:0]
//  out_ch    out  valid / ready    pressed, click_event, double_click_event, long_press_event
//  cfg_*     in   cfg_we           cfg_index[1:0], cfg_wdata[31:0]
//
// one poll per cycle sustained while out_ch is ready; the accepting edge registers the poll
// and the state memory read; then, once the pipeline advances, the state is updated and
// written back and the result register is loaded; the last write is forwarded to a
// following poll of that button
// synchronous reset marks every button entry as untouched (reads as idle, all zero)
// a stalled result holds the pipeline; in_ch.ready follows out_ch.ready combinationally
// and is low during reset
`default_nettype none
module button_click_gesture_detector
  import bcg_pkg::*;
#(
  parameter int BUTTONS = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  bcg_in_if.sink           in_ch,
  bcg_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);
  localparam int AW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
  localparam int SW = $bits(button_rec_t);

  // configuration registers
  logic [15:0] debounce_r;
  logic [31:0] long_press_r;
  logic [15:0] dbl_gap_r;
  logic [27:0] click_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RST;
      long_press_r <= LONG_PRESS_RST;
      dbl_gap_r    <= DBL_GAP_RST;
      click_max_r  <= CLICK_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE:   debounce_r   <= cfg_wdata[15:0];
        REG_LONG_PRESS: long_press_r <= cfg_wdata;
        REG_DBL_GAP:    dbl_gap_r    <= cfg_wdata[15:0];
        REG_CLICK_MAX:  click_max_r  <= cfg_wdata[27:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic advance;
  logic in_acc;
  logic out_valid_r;

  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = advance && rst_n;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // read stage registers
  logic          s1_valid_r;
  logic          s1_inrange_r;
  logic [AW-1:0] s1_addr_r;
  logic          s1_pr_r;
  logic [31:0]   s1_now_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_inrange_r <= ({1'b0, in_ch.button_index} < 5'(BUTTONS));
      s1_addr_r    <= in_ch.button_index[AW-1:0];
      s1_pr_r      <= !in_ch.pin_level;
      s1_now_r     <= in_ch.time_ms;
    end
  end

  // state memory
  logic               wr_en;
  button_rec_t        st_nxt;
  logic [SW-1:0]      ram_rdata;

  bcg_ram #(
    .WIDTH (SW),
    .DEPTH (BUTTONS)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr_r),
    .wdata (st_nxt),
    .re    (in_acc),
    .raddr (in_ch.button_index[AW-1:0]),
    .rdata (ram_rdata)
  );

  // entry written flags and last write for forwarding
  logic [BUTTONS-1:0] ent_valid_r;
  logic               lw_valid_r;
  logic [AW-1:0]      lw_addr_r;
  button_rec_t        lw_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= '0;
      lw_valid_r  <= 1'b0;
    end else if (wr_en) begin
      ent_valid_r[s1_addr_r] <= 1'b1;
      lw_valid_r             <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lw_addr_r <= s1_addr_r;
      lw_data_r <= st_nxt;
    end
  end

  // current state of the polled button
  button_rec_t st_cur;

  always_comb begin
    if (lw_valid_r && (lw_addr_r == s1_addr_r)) begin
      st_cur = lw_data_r;
    end else if (ent_valid_r[s1_addr_r]) begin
      st_cur = button_rec_t'(ram_rdata);
    end else begin
      st_cur = '0;
    end
  end

  // state update
  logic [31:0] elapsed;
  logic        short_press;
  logic        ev_click;
  logic        ev_double;
  logic        ev_long;
  logic        pr;
  logic        prev;

  assign pr          = s1_pr_r;
  assign prev        = st_cur.previous_pressed;
  assign elapsed     = s1_now_r - st_cur.start_time;
  assign short_press = (st_cur.press_duration[31:4] <= click_max_r);

  always_comb begin
    st_nxt    = st_cur;
    ev_click  = 1'b0;
    ev_double = 1'b0;
    ev_long   = 1'b0;
    case (st_cur.phase)
      PH_IDLE: begin
        if (pr && !prev) begin
          st_nxt.phase      = PH_DEBOUNCE;
          st_nxt.start_time = s1_now_r;
          st_nxt.long_fired = 1'b0;
        end
      end
      PH_DEBOUNCE: begin
        if (elapsed >= {16'd0, debounce_r}) begin
          if (pr) begin
            st_nxt.phase = PH_PRESSED;
            if (st_cur.click_count != 2'd3) begin
              st_nxt.click_count = st_cur.click_count + 2'd1;
            end
          end else begin
            st_nxt.phase = PH_IDLE;
          end
        end
      end
      PH_PRESSED: begin
        if (pr || !prev) begin
          if (!st_cur.long_fired && (elapsed >= long_press_r)) begin
            st_nxt.phase      = PH_LONG;
            st_nxt.long_fired = 1'b1;
            ev_long           = 1'b1;
          end
        end else begin
          st_nxt.phase          = PH_RELEASE;
          st_nxt.press_duration = elapsed;
          st_nxt.start_time     = s1_now_r;
        end
      end
      PH_RELEASE: begin
        if (elapsed >= {16'd0, debounce_r}) begin
          if (pr) begin
            st_nxt.phase = PH_PRESSED;
          end else if ((st_cur.click_count == 2'd1) && short_press) begin
            st_nxt.phase      = PH_WAIT2;
            st_nxt.start_time = s1_now_r;
          end else begin
            ev_double          = st_cur.click_count[1] && short_press;
            st_nxt.phase       = PH_IDLE;
            st_nxt.click_count = 2'd0;
          end
        end
      end
      PH_WAIT2: begin
        if (!pr || prev) begin
          if (elapsed >= {16'd0, dbl_gap_r}) begin
            ev_click           = (st_cur.click_count == 2'd1);
            st_nxt.phase       = PH_IDLE;
            st_nxt.click_count = 2'd0;
          end
        end else begin
          st_nxt.phase      = PH_DEBOUNCE;
          st_nxt.start_time = s1_now_r;
        end
      end
      PH_LONG: begin
        if (!pr && prev) begin
          st_nxt.phase          = PH_RELEASE;
          st_nxt.press_duration = elapsed;
          st_nxt.start_time     = s1_now_r;
        end
      end
      default: ;
    endcase
    st_nxt.previous_pressed = pr;
  end

  assign wr_en = s1_valid_r && s1_inrange_r && advance;

  // result register
  logic out_pressed_r;
  logic out_click_r;
  logic out_double_r;
  logic out_long_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_pressed_r <= s1_inrange_r && pr;
      out_click_r   <= s1_inrange_r && ev_click;
      out_double_r  <= s1_inrange_r && ev_double;
      out_long_r    <= s1_inrange_r && ev_long;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.pressed            = out_pressed_r;
  assign out_ch.click_event        = out_click_r;
  assign out_ch.double_click_event = out_double_r;
  assign out_ch.long_press_event   = out_long_r;

endmodule
`default_nettype wire
